// ----- rtl/telomeric_repeat_checker_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the telomeric repeat checker.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TELOMERIC_REPEAT_CHECKER_UNIT_MACROS_SVH
`define TELOMERIC_REPEAT_CHECKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("telomeric repeat checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("telomeric repeat checker: next-cycle property failed");

`endif

// ----- rtl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg
// Shared constants, phase codes and the pattern table of the telomeric
// repeat checker.
// ----------------------------------------------------------------------------
package trc_pkg;

    // Fixed field widths of the channels.
    localparam int TRC_CHAR_BITS        = 8;
    localparam int TRC_HIT_BITS         = 16;
    localparam int TRC_SUPPORT_OUT_BITS = 24;

    // Defaults for the top-level parameters.
    localparam int TRC_LENGTH_BITS_DEF  = 16;
    localparam int TRC_SUPPORT_BITS_DEF = 24;

    // Parse phases of one record.
    localparam logic [1:0] TRC_PH_PREFIX      = 2'd0;
    localparam logic [1:0] TRC_PH_AFTER_COLON = 2'd1;
    localparam logic [1:0] TRC_PH_SEQ         = 2'd2;
    localparam logic [1:0] TRC_PH_DONE        = 2'd3;

    // Characters that steer the parser.
    localparam logic [7:0] TRC_CH_COLON = 8'h3A;
    localparam logic [7:0] TRC_CH_BAR   = 8'h7C;
    localparam logic [7:0] TRC_CH_PAREN = 8'h28;
    localparam logic [7:0] TRC_CH_ZERO  = 8'h30;
    localparam logic [7:0] TRC_CH_NINE  = 8'h39;

    // Pass rule constants. The hit ratio of 0.06 is checked as
    // 50 * hits >= 3 * length.
    localparam logic [2:0] TRC_PAT_LEN       = 3'd6;
    localparam int         TRC_MIN_SUPPORT   = 7;
    localparam int         TRC_MIN_HITS_EXCL = 3;
    localparam int         TRC_END_GAP       = 6;
    localparam int         TRC_RATIO_HIT_MUL = 50;
    localparam int         TRC_RATIO_LEN_MUL = 3;

    // Pattern character at a match position: TTAGGG, or CCCTAA when inverted.
    function automatic logic [7:0] trc_pat_char(input logic inv, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (pos)
            3'd0: ch = inv ? 8'h43 : 8'h54;
            3'd1: ch = inv ? 8'h43 : 8'h54;
            3'd2: ch = inv ? 8'h43 : 8'h41;
            3'd3: ch = inv ? 8'h54 : 8'h47;
            3'd4: ch = inv ? 8'h41 : 8'h47;
            3'd5: ch = inv ? 8'h41 : 8'h47;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/trc_char_if.sv -----
// ----------------------------------------------------------------------------
// trc_char_if
// Character channel: one record character and its framing marks per beat.
// ----------------------------------------------------------------------------
interface trc_char_if import trc_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [TRC_CHAR_BITS-1:0] char_code;
    logic                     inv_mode;
    logic                     m_mode;
    logic                     first_char;
    logic                     last_char;

    modport source (
        output valid,
        input  ready,
        output char_code,
        output inv_mode,
        output m_mode,
        output first_char,
        output last_char
    );

    modport sink (
        input  valid,
        output ready,
        input  char_code,
        input  inv_mode,
        input  m_mode,
        input  first_char,
        input  last_char
    );

endinterface

// ----- rtl/trc_verdict_if.sv -----
// ----------------------------------------------------------------------------
// trc_verdict_if
// Verdict channel: one pass/fail result per record.
// ----------------------------------------------------------------------------
interface trc_verdict_if import trc_pkg::*; ();

    logic                            valid;
    logic                            ready;
    logic                            qualifies;
    logic [TRC_SUPPORT_OUT_BITS-1:0] support;
    logic [TRC_HIT_BITS-1:0]         hit_count;

    modport source (
        output valid,
        input  ready,
        output qualifies,
        output support,
        output hit_count
    );

    modport sink (
        input  valid,
        output ready,
        input  qualifies,
        input  support,
        input  hit_count
    );

endinterface

// ----- rtl/trc_count.sv -----
// ----------------------------------------------------------------------------
// trc_count
// Support count parser: decimal accumulation of the run after the last '('
// and before the final character, with saturation and a non-digit flag.
// ----------------------------------------------------------------------------
module trc_count import trc_pkg::*; #(
    parameter int SUPPORT_BITS = TRC_SUPPORT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [TRC_CHAR_BITS-1:0] char_code,
    input  logic                     first_char,
    input  logic                     last_char,
    output logic [SUPPORT_BITS-1:0]  acc_next,
    output logic                     bad_next
);

    localparam int CW = SUPPORT_BITS + 4;

    logic [SUPPORT_BITS-1:0] acc_reg;
    logic                    bad_reg;
    logic [SUPPORT_BITS-1:0] acc_base;
    logic                    bad_base;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [CW-1:0]           acc_mul;

    always_comb
    begin
        acc_base = first_char ? '0 : acc_reg;
        bad_base = first_char ? 1'b0 : bad_reg;
        is_digit = (char_code >= TRC_CH_ZERO) && (char_code <= TRC_CH_NINE);
        digit    = 4'(char_code - TRC_CH_ZERO);
        acc_mul  = CW'(acc_base) * CW'(10) + CW'(digit);

        acc_next = acc_base;
        bad_next = bad_base;
        if (char_code == TRC_CH_PAREN)
        begin
            acc_next = '0;
            bad_next = 1'b0;
        end
        else if (!last_char)
        begin
            if (is_digit)
            begin
                if (acc_mul > CW'({SUPPORT_BITS{1'b1}}))
                    acc_next = '1;
                else
                    acc_next = acc_mul[SUPPORT_BITS-1:0];
            end
            else
            begin
                bad_next = 1'b1;
            end
        end
    end

    // The run is cleared when the last character of a record is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg <= last_char ? '0 : acc_next;
            bad_reg <= last_char ? 1'b0 : bad_next;
        end
    end

endmodule

// ----- rtl/telomeric_repeat_checker_unit.sv -----
// ----------------------------------------------------------------------------
// telomeric_repeat_checker_unit
// Per-character checker that decides whether an overhang record is a
// telomeric repeat and reports its support count.
// ----------------------------------------------------------------------------
// The block takes one character of an overhang record per beat and gives one
// verdict beat for each character marked as the last of its record; other
// characters give no verdict. It accepts a character in every clock cycle
// while the verdict register is empty or being drained, and while a verdict
// waits it can still fill an empty input register: a character enters an
// input register, and a single pass of logic then folds it into the running
// record state (parse phase, match position, hit and length counters, the
// support count run) and, on the last character, loads the verdict register;
// this pass waits while the verdict register is full and not being drained.
// A verdict is therefore offered once its last character has left the input
// register through that pass. The input side stalls only when the verdict
// register is full, not being drained, and the input register is occupied.
// Records are framed by first_char, which clears the running state and
// latches the two mode bits; without it, characters simply continue the
// current record, and the state is cleared after every verdict while the
// mode bits are kept. The hit ratio test of 0.06 is made exactly as
// 50 * hits >= 3 * length. The sequence length and the support accumulator
// have widths LENGTH_BITS and SUPPORT_BITS and saturate; the reported support saturates at the 24-bit field maximum.
// ----------------------------------------------------------------------------
module telomeric_repeat_checker_unit import trc_pkg::*; #(
    parameter int LENGTH_BITS  = TRC_LENGTH_BITS_DEF,
    parameter int SUPPORT_BITS = TRC_SUPPORT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    trc_char_if.sink     chars,
    trc_verdict_if.source verdict
);

    localparam int RATIO_W = (LENGTH_BITS + 2 > TRC_HIT_BITS + 6) ?
                             (LENGTH_BITS + 2) : (TRC_HIT_BITS + 6);
    localparam int SUP_W   = (SUPPORT_BITS > TRC_SUPPORT_OUT_BITS) ?
                             SUPPORT_BITS : TRC_SUPPORT_OUT_BITS;

    // Input register.
    logic                     s1_valid_reg;
    logic [TRC_CHAR_BITS-1:0] s1_char_reg;
    logic                     s1_inv_reg;
    logic                     s1_m_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;

    // Running record state.
    logic [1:0]              phase_reg;
    logic [2:0]              pos_reg;
    logic [TRC_HIT_BITS-1:0] hits_reg;
    logic [LENGTH_BITS-1:0]  len_reg;
    logic [LENGTH_BITS-1:0]  end_reg;
    logic                    adj_reg;
    logic                    bar_reg;
    logic [1:0]              mode_reg;

    // Verdict register.
    logic                            res_valid_reg;
    logic                            res_qual_reg;
    logic [TRC_SUPPORT_OUT_BITS-1:0] res_support_reg;
    logic [TRC_HIT_BITS-1:0]         res_hits_reg;

    logic can_go;
    logic in_take;
    logic step;

    // Base state: cleared when the character opens a record.
    logic [1:0]              mode_cur;
    logic [1:0]              b_phase;
    logic [2:0]              b_pos;
    logic [TRC_HIT_BITS-1:0] b_hits;
    logic [LENGTH_BITS-1:0]  b_len;
    logic [LENGTH_BITS-1:0]  b_end;
    logic                    b_adj;
    logic                    b_bar;

    // State after this character.
    logic [1:0]              u_phase;
    logic [2:0]              u_pos;
    logic [TRC_HIT_BITS-1:0] u_hits;
    logic [LENGTH_BITS-1:0]  u_len;
    logic [LENGTH_BITS-1:0]  u_end;
    logic                    u_adj;
    logic                    u_bar;

    logic                    do_scan;
    logic                    is_stop;
    logic                    pat_match;
    logic [2:0]              pos_inc;

    logic [SUPPORT_BITS-1:0] acc_next;
    logic                    bad_next;
    logic [SUP_W-1:0]        acc_ext;
    logic [TRC_SUPPORT_OUT_BITS-1:0] sup_sat;
    logic                    ratio_ok;
    logic                    pass;

    // The pipeline advances whenever the verdict register can take a new value.
    assign can_go        = !res_valid_reg || verdict.ready;
    assign chars.ready   = !s1_valid_reg || can_go;
    assign in_take       = chars.valid && chars.ready;
    assign step          = s1_valid_reg && can_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (chars.ready)
            s1_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg  <= chars.char_code;
            s1_inv_reg   <= chars.inv_mode;
            s1_m_reg     <= chars.m_mode;
            s1_first_reg <= chars.first_char;
            s1_last_reg  <= chars.last_char;
        end
    end

    trc_count #(
        .SUPPORT_BITS (SUPPORT_BITS)
    ) u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_code  (s1_char_reg),
        .first_char (s1_first_reg),
        .last_char  (s1_last_reg),
        .acc_next   (acc_next),
        .bad_next   (bad_next)
    );

    always_comb
    begin
        mode_cur = s1_first_reg ? {s1_m_reg, s1_inv_reg} : mode_reg;
        b_phase  = s1_first_reg ? TRC_PH_PREFIX : phase_reg;
        b_pos    = s1_first_reg ? 3'd0 : pos_reg;
        b_hits   = s1_first_reg ? '0 : hits_reg;
        b_len    = s1_first_reg ? '0 : len_reg;
        b_end    = s1_first_reg ? '0 : end_reg;
        b_adj    = s1_first_reg ? 1'b0 : adj_reg;
        b_bar    = s1_first_reg ? 1'b0 : bar_reg;

        is_stop   = (s1_char_reg == TRC_CH_BAR) || (s1_char_reg == TRC_CH_PAREN);
        pat_match = (s1_char_reg == trc_pat_char(mode_cur[0], b_pos));
        pos_inc   = b_pos + 3'd1;

        u_phase = b_phase;
        u_pos   = b_pos;
        u_hits  = b_hits;
        u_len   = b_len;
        u_end   = b_end;
        u_adj   = b_adj;
        u_bar   = b_bar;
        do_scan = 1'b0;

        case (b_phase)
            TRC_PH_PREFIX:
            begin
                if (s1_char_reg == TRC_CH_COLON)
                    u_phase = TRC_PH_AFTER_COLON;
            end
            TRC_PH_AFTER_COLON:
            begin
                u_phase = TRC_PH_SEQ;
                if (s1_char_reg == TRC_CH_BAR)
                    u_bar = 1'b1;
                else
                    do_scan = 1'b1;
            end
            TRC_PH_SEQ:
            begin
                do_scan = 1'b1;
            end
            default:
            begin
                do_scan = 1'b0;
            end
        endcase

        // One step of the pattern matcher; a mismatch restarts without
        // rechecking the character.
        if (do_scan)
        begin
            if (is_stop)
            begin
                u_phase = TRC_PH_DONE;
            end
            else
            begin
                if (pat_match)
                begin
                    if (pos_inc >= TRC_PAT_LEN)
                    begin
                        u_pos = 3'd0;
                        if ((b_hits != '0) && (b_len >= b_end) &&
                            ((b_len - b_end) == LENGTH_BITS'(TRC_END_GAP)))
                            u_adj = 1'b1;
                        u_end = b_len;
                        if (b_hits != '1)
                            u_hits = b_hits + 1'b1;
                    end
                    else
                    begin
                        u_pos = pos_inc;
                    end
                end
                else
                begin
                    u_pos = 3'd0;
                end
                if (b_len != '1)
                    u_len = b_len + 1'b1;
            end
        end
    end

    // Verdict on the state after the last character.
    always_comb
    begin
        ratio_ok = (RATIO_W'(u_hits) * RATIO_W'(TRC_RATIO_HIT_MUL)) >=
                   (RATIO_W'(u_len) * RATIO_W'(TRC_RATIO_LEN_MUL));
        pass = (u_phase != TRC_PH_PREFIX) &&
               (u_bar == mode_cur[1]) &&
               !bad_next &&
               (acc_next >= SUPPORT_BITS'(TRC_MIN_SUPPORT)) &&
               (u_hits > TRC_HIT_BITS'(TRC_MIN_HITS_EXCL)) &&
               ratio_ok &&
               u_adj;
        acc_ext = SUP_W'(acc_next);
        if (acc_ext > SUP_W'({TRC_SUPPORT_OUT_BITS{1'b1}}))
            sup_sat = '1;
        else
            sup_sat = acc_ext[TRC_SUPPORT_OUT_BITS-1:0];
    end

    // Running state; cleared after each verdict, mode bits kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= TRC_PH_PREFIX;
            pos_reg   <= 3'd0;
            hits_reg  <= '0;
            len_reg   <= '0;
            end_reg   <= '0;
            adj_reg   <= 1'b0;
            bar_reg   <= 1'b0;
            mode_reg  <= 2'b00;
        end
        else if (step)
        begin
            mode_reg <= mode_cur;
            if (s1_last_reg)
            begin
                phase_reg <= TRC_PH_PREFIX;
                pos_reg   <= 3'd0;
                hits_reg  <= '0;
                len_reg   <= '0;
                end_reg   <= '0;
                adj_reg   <= 1'b0;
                bar_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= u_phase;
                pos_reg   <= u_pos;
                hits_reg  <= u_hits;
                len_reg   <= u_len;
                end_reg   <= u_end;
                adj_reg   <= u_adj;
                bar_reg   <= u_bar;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step && s1_last_reg)
            res_valid_reg <= 1'b1;
        else if (verdict.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            res_qual_reg    <= pass;
            res_support_reg <= pass ? sup_sat : '0;
            res_hits_reg    <= u_hits;
        end
    end

    assign verdict.valid     = res_valid_reg;
    assign verdict.qualifies = res_qual_reg;
    assign verdict.support   = res_support_reg;
    assign verdict.hit_count = res_hits_reg;

endmodule

// ----- rtl/trc_checker.sv -----
// ----------------------------------------------------------------------------
// trc_checker
// Port-level assertions for the telomeric repeat checker, bound to the top.
// ----------------------------------------------------------------------------
`include "telomeric_repeat_checker_unit_macros.svh"

module trc_checker import trc_pkg::*; (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            qualifies,
    input logic [TRC_SUPPORT_OUT_BITS-1:0] support,
    input logic [TRC_HIT_BITS-1:0]         hit_count
);

    // A passing record must carry enough support and enough hits.
    `TRC_ASSERT_SAME(a_pass_support, clk, rst_n, out_valid && qualifies, support >= TRC_SUPPORT_OUT_BITS'(TRC_MIN_SUPPORT))
    `TRC_ASSERT_SAME(a_pass_hits, clk, rst_n, out_valid && qualifies, hit_count > TRC_HIT_BITS'(TRC_MIN_HITS_EXCL))

    // A failing record reports no support.
    `TRC_ASSERT_SAME(a_fail_support, clk, rst_n, out_valid && !qualifies, support == '0)

    // A stalled verdict beat stays offered.
    `TRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind telomeric_repeat_checker_unit trc_checker u_trc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .qualifies (verdict.qualifies),
    .support   (verdict.support),
    .hit_count (verdict.hit_count)
);
